// ----- src/leakage_reduction_scheduler_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Leakage reduction scheduler assertion macros
// Shorthand for the concurrent checks of the scheduler's checker module.
// ----------------------------------------------------------------------------
`ifndef LEAKAGE_REDUCTION_SCHEDULER_UNIT_ASSERT_SVH
`define LEAKAGE_REDUCTION_SCHEDULER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LRS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scheduler check failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define LRS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scheduler check failed: next-cycle implication");

`endif

// ----- src/lrs_pkg.sv -----
// ----------------------------------------------------------------------------
// Leakage reduction scheduler package
// Shared constants, the front-to-back work record and qubit set helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package lrs_pkg;

	localparam int QUBIT_W      = 6;
	localparam int QUBIT_COUNT  = 64;
	localparam int SET_W        = 1 << QUBIT_W;
	localparam int DEG_W        = 3;
	localparam int DEGREE_LIMIT = 4;

	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

	// Front stage, queue entries and the output register.
	localparam int MAX_IN_FLIGHT = QUEUE_DEPTH + 2;
	localparam int FLIGHT_W      = $clog2(MAX_IN_FLIGHT + 4);

	typedef logic [QUBIT_W-1:0] qubit_t;
	typedef logic [SET_W-1:0]   qset_t;

	// One classified data qubit handed from the front to the back.
	typedef struct packed {
		qubit_t data_qubit;
		qubit_t first_partner;
		qubit_t second_partner;
		logic   eligible;
		logic   syndrome_nonzero;
		logic   last_in_round;
	} work_t;

	function automatic logic in_range(input qubit_t q);
		return (32'(q) < QUBIT_COUNT);
	endfunction

	function automatic logic set_test(input qset_t s, input qubit_t q);
		return in_range(q) && s[q];
	endfunction

	function automatic qset_t set_mark(input qubit_t q);
		qset_t m;
		m = '0;
		if (in_range(q)) begin
			m[q] = 1'b1;
		end
		return m;
	endfunction

endpackage

`default_nettype wire

// ----- src/lrs_item_if.sv -----
// ----------------------------------------------------------------------------
// Scheduler input channel
// Valid/ready channel carrying one data qubit of a syndrome round.
// ----------------------------------------------------------------------------
`default_nettype none

interface lrs_item_if;
	logic                          valid;
	logic                          ready;
	logic [lrs_pkg::QUBIT_W-1:0]   data_qubit;
	logic [lrs_pkg::DEG_W-1:0]     check_degree;
	logic [lrs_pkg::DEG_W-1:0]     flipped_neighbors;
	logic [lrs_pkg::QUBIT_W-1:0]   first_partner;
	logic [lrs_pkg::QUBIT_W-1:0]   second_partner;
	logic                          syndrome_nonzero;
	logic                          last_in_round;

	modport source (
		output valid, data_qubit, check_degree, flipped_neighbors,
		       first_partner, second_partner, syndrome_nonzero, last_in_round,
		input  ready
	);

	modport sink (
		input  valid, data_qubit, check_degree, flipped_neighbors,
		       first_partner, second_partner, syndrome_nonzero, last_in_round,
		output ready
	);
endinterface

`default_nettype wire

// ----- src/lrs_result_if.sv -----
// ----------------------------------------------------------------------------
// Scheduler result channel
// Valid/ready channel carrying the swap decision for one data qubit.
// ----------------------------------------------------------------------------
`default_nettype none

interface lrs_result_if;
	logic                          valid;
	logic                          ready;
	logic                          scheduled;
	logic [lrs_pkg::QUBIT_W-1:0]   chosen_partner;
	logic                          round_had_lrc;

	modport source (
		output valid, scheduled, chosen_partner, round_had_lrc,
		input  ready
	);

	modport sink (
		input  valid, scheduled, chosen_partner, round_had_lrc,
		output ready
	);
endinterface

`default_nettype wire

// ----- src/leakage_reduction_scheduler_unit.sv -----
// ----------------------------------------------------------------------------
// Leakage reduction scheduler unit
// Decides per data qubit whether it gets a leakage reduction swap, and with whom.
// ----------------------------------------------------------------------------
// Usage: the item channel takes one data qubit of a syndrome round per
// transaction, with its check degree, flip count, two swap partners in
// preference order, the round's syndrome flag and a last-in-round mark.
// Every item gives exactly one transaction on the result channel, in order:
// the scheduled flag, the claimed partner (zero when not scheduled) and, on
// the last item of a round, whether any swap was scheduled in that round.
// An accepted item passes the staging register, a queue entry and the
// output register. Throughput is one item per cycle while the result
// channel is ready; it is set by the partner claim in the back end, which
// reads and updates the in-use and recent qubit sets held in flip-flops.
// Reset clears both qubit sets, the round flag, the staging register, the
// queue and the output register; no clearing pass is needed. When the
// receiver stalls, the result stays in the output register, the back end
// stops, the queue fills, and only then does the item channel drop ready.
// At most four items are in flight inside the block.
// ----------------------------------------------------------------------------
`default_nettype none

module leakage_reduction_scheduler_unit (
	input  wire logic      clk,
	input  wire logic      arst_n,
	lrs_item_if.sink       item,
	lrs_result_if.source   result
);

	// Front end to queue: classified items staged in the cycle after acceptance.
	lrs_pkg::work_t  front_wk;
	logic            front_valid;
	logic            front_ready;

	// Queue to back end: oldest classified item waiting for a decision.
	lrs_pkg::work_t  back_wk;
	logic            back_valid;
	logic            back_ready;

	// The front end clamps the degree and applies the flip threshold and the
	// syndrome flag, so the back end only has to consult the qubit sets.
	lrs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.wk       (front_wk),
		.wk_valid (front_valid),
		.wk_ready (front_ready)
	);

	// The queue decouples the two sides, so a stalled result does not stop
	// acceptance until the queue is full.
	lrs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_data  (front_wk),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.pop_data   (back_wk),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready)
	);

	// The back end owns the round state: it claims the first free partner,
	// updates the in-use set, and at round end moves it into the recent set
	// unless the syndrome on the last item was zero.
	lrs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.wk       (back_wk),
		.wk_valid (back_valid),
		.wk_ready (back_ready),
		.result   (result)
	);

endmodule

`default_nettype wire

// ----- src/lrs_front.sv -----
// ----------------------------------------------------------------------------
// Scheduler front end
// Accepts data qubits, applies the flip threshold and stages them for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lrs_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	lrs_item_if.sink           item,
	output lrs_pkg::work_t     wk,
	output logic               wk_valid,
	input  wire logic          wk_ready
);

	logic                 valid_s1;
	lrs_pkg::work_t       wk_s1;
	lrs_pkg::work_t       wk_d;
	logic [lrs_pkg::DEG_W:0] deg_clamped;
	logic                 accept;
	logic                 push;

	// A degree above the limit counts as the limit; the threshold is half of it.
	always_comb begin
		if ({1'b0, item.check_degree} > (lrs_pkg::DEG_W + 1)'(lrs_pkg::DEGREE_LIMIT)) begin
			deg_clamped = (lrs_pkg::DEG_W + 1)'(lrs_pkg::DEGREE_LIMIT);
		end else begin
			deg_clamped = {1'b0, item.check_degree};
		end
		wk_d.data_qubit       = item.data_qubit;
		wk_d.first_partner    = item.first_partner;
		wk_d.second_partner   = item.second_partner;
		wk_d.syndrome_nonzero = item.syndrome_nonzero;
		wk_d.last_in_round    = item.last_in_round;
		wk_d.eligible         = item.syndrome_nonzero &&
		                        ({1'b0, item.flipped_neighbors} >= (deg_clamped >> 1));
	end

	assign push       = valid_s1 && wk_ready;
	assign item.ready = !valid_s1 || wk_ready;
	assign accept     = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			wk_s1 <= wk_d;
		end
	end

	assign wk       = wk_s1;
	assign wk_valid = valid_s1;

endmodule

`default_nettype wire

// ----- src/lrs_queue.sv -----
// ----------------------------------------------------------------------------
// Scheduler work queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lrs_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire lrs_pkg::work_t push_data,
	input  wire logic           push_valid,
	output logic                push_ready,
	output lrs_pkg::work_t      pop_data,
	output logic                pop_valid,
	input  wire logic           pop_ready
);

	lrs_pkg::work_t                mem_q [lrs_pkg::QUEUE_DEPTH];
	logic [lrs_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [lrs_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [lrs_pkg::QCNT_W-1:0]    count_q;
	logic                          do_push;
	logic                          do_pop;

	function automatic logic [lrs_pkg::QPTR_W-1:0] next_ptr(
		input logic [lrs_pkg::QPTR_W-1:0] p
	);
		if (32'(p) == lrs_pkg::QUEUE_DEPTH - 1) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	assign push_ready = (32'(count_q) < lrs_pkg::QUEUE_DEPTH);
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ----- src/lrs_back.sv -----
// ----------------------------------------------------------------------------
// Scheduler back end
// Claims swap partners against the round sets and registers each decision.
// ----------------------------------------------------------------------------
`default_nettype none

module lrs_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire lrs_pkg::work_t wk,
	input  wire logic           wk_valid,
	output logic                wk_ready,
	lrs_result_if.source        result
);

	lrs_pkg::qset_t   recent_q;
	lrs_pkg::qset_t   in_use_q;
	logic             any_q;
	lrs_pkg::qset_t   in_use_next;
	logic             any_next;

	logic             out_valid_q;
	logic             scheduled_q;
	lrs_pkg::qubit_t  partner_q;
	logic             lrc_q;

	logic             fire;
	logic             p0_free;
	logic             p1_free;
	logic             sched;
	lrs_pkg::qubit_t  chosen;

	// The back end takes a new transaction whenever the output register is
	// empty or being drained in this cycle.
	assign fire     = wk_valid && (!out_valid_q || result.ready);
	assign wk_ready = fire;

	always_comb begin
		p0_free = !lrs_pkg::set_test(in_use_q, wk.first_partner) &&
		          !lrs_pkg::set_test(recent_q, wk.first_partner);
		p1_free = !lrs_pkg::set_test(in_use_q, wk.second_partner) &&
		          !lrs_pkg::set_test(recent_q, wk.second_partner);
		sched   = wk.eligible && !lrs_pkg::set_test(recent_q, wk.data_qubit) &&
		          (p0_free || p1_free);
		if (!sched) begin
			chosen = '0;
		end else if (p0_free) begin
			chosen = wk.first_partner;
		end else begin
			chosen = wk.second_partner;
		end
		in_use_next = in_use_q;
		if (sched) begin
			in_use_next = in_use_q | lrs_pkg::set_mark(wk.data_qubit) |
			              lrs_pkg::set_mark(chosen);
		end
		any_next = any_q || sched;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_q <= '0;
			in_use_q <= '0;
			any_q    <= 1'b0;
		end else if (fire) begin
			if (wk.last_in_round) begin
				if (wk.syndrome_nonzero) begin
					recent_q <= in_use_next;
				end
				in_use_q <= '0;
				any_q    <= 1'b0;
			end else begin
				in_use_q <= in_use_next;
				any_q    <= any_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			scheduled_q <= sched;
			partner_q   <= chosen;
			lrc_q       <= wk.last_in_round && any_next;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.scheduled      = scheduled_q;
	assign result.chosen_partner = partner_q;
	assign result.round_had_lrc  = lrc_q;

endmodule

`default_nettype wire

// ----- src/lrs_checker.sv -----
// ----------------------------------------------------------------------------
// Leakage reduction scheduler checker
// Port-level checks on result holding, payload and items in flight, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "leakage_reduction_scheduler_unit_assert.svh"

module lrs_checker (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        item_valid,
	input  wire logic                        item_ready,
	input  wire logic                        result_valid,
	input  wire logic                        result_ready,
	input  wire logic                        result_scheduled,
	input  wire logic [lrs_pkg::QUBIT_W-1:0] result_chosen_partner
);

	logic [lrs_pkg::FLIGHT_W-1:0] flight_q;
	logic                         item_acc;
	logic                         result_acc;

	assign item_acc   = item_valid && item_ready;
	assign result_acc = result_valid && result_ready;

	// Items accepted and not yet delivered as results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flight_q <= '0;
		end else if (item_acc && !result_acc) begin
			flight_q <= flight_q + 1'b1;
		end else if (result_acc && !item_acc) begin
			flight_q <= flight_q - 1'b1;
		end
	end

	`LRS_ASSERT_NEXT(a_result_held, result_valid && !result_ready, result_valid && $stable(result_chosen_partner))
	`LRS_ASSERT_NOW(a_partner_zero, result_valid && !result_scheduled, result_chosen_partner == '0)
	`LRS_ASSERT_NOW(a_no_invented_result, result_valid, flight_q != '0)
	`LRS_ASSERT_NOW(a_flight_bounded, 1'b1, 32'(flight_q) <= lrs_pkg::MAX_IN_FLIGHT)

endmodule

bind leakage_reduction_scheduler_unit lrs_checker u_lrs_checker (
	.clk                   (clk),
	.arst_n                (arst_n),
	.item_valid            (item.valid),
	.item_ready            (item.ready),
	.result_valid          (result.valid),
	.result_ready          (result.ready),
	.result_scheduled      (result.scheduled),
	.result_chosen_partner (result.chosen_partner)
);

`default_nettype wire
